// File: sv/usg_pkg.sv
// shared types, constants and helpers for the update send governor
package usg_pkg;

	// heartbeat period default
	localparam int unsigned HEARTBEAT_MS_DEF = 30000;

	// item command codes
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEND_BRIGHTNESS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EFFECT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 3'd6;
	localparam int unsigned CFG_DATA_W = 32;

	// configuration reset values
	localparam logic [7:0]  BRIGHTNESS_RST      = 8'd255;
	localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd100;

	// backoff steps and failure ceiling
	localparam logic [14:0] BACKOFF_1 = 15'd1000;
	localparam logic [14:0] BACKOFF_2 = 15'd2000;
	localparam logic [14:0] BACKOFF_3 = 15'd5000;
	localparam logic [14:0] BACKOFF_4 = 15'd10000;
	localparam logic [14:0] BACKOFF_5 = 15'd30000;
	localparam logic [7:0]  FAIL_MAX  = 8'd255;

	// input item
	typedef struct packed {
		logic        cmd;
		logic [31:0] now_ms;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        light_on;
		logic        force_req;
		logic        release_after_send;
		logic [15:0] interval_ceiling_ms;
		logic        send_ok;
	} in_item_t;

	// result item
	typedef struct packed {
		logic        send_request;
		logic [7:0]  send_red;
		logic [7:0]  send_green;
		logic [7:0]  send_blue;
		logic        send_on;
		logic [7:0]  failure_count;
		logic [14:0] retry_delay_ms;
		logic        release_done;
	} out_item_t;

	// configuration registers
	typedef struct packed {
		logic        enabled;
		logic [31:0] target_id;
		logic [7:0]  segment;
		logic [7:0]  brightness;
		logic        send_brightness;
		logic        keep_effect;
		logic [15:0] update_interval_ms;
	} cfg_t;

	// config as recorded at the last successful send
	typedef struct packed {
		logic        enabled;
		logic [31:0] target_id;
		logic [7:0]  segment;
		logic [7:0]  brightness;
		logic        send_brightness;
		logic        keep_effect;
	} snap_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_report;
		logic [31:0] now_ms;
		logic [23:0] colour;
		logic        light_on;
		logic        force_req;
		logic        rel;
		logic [15:0] interval_ms;
		logic        send_ok;
	} op_t;

	// backoff delay for a given failure count
	function automatic logic [14:0] backoff_for(input logic [7:0] failures);
		logic [14:0] d;
		begin
			priority if (failures <= 8'd1) begin
				d = BACKOFF_1;
			end else if (failures == 8'd2) begin
				d = BACKOFF_2;
			end else if (failures == 8'd3) begin
				d = BACKOFF_3;
			end else if (failures == 8'd4) begin
				d = BACKOFF_4;
			end else begin
				d = BACKOFF_5;
			end
			return d;
		end
	endfunction

endpackage

// File: sv/update_send_governor.sv
// top level of the update send governor: config registers, front, queue, back
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries update requests
//   (cmd 0) and send-outcome reports (cmd 1). An item is taken at a clock
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_item) returns exactly one
//   result item per input item, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes one
//   register per handshake; cfg_ready is always high. Write only when idle.
// Timing:
//   An item accepted with the queue empty and the result slot free has its
//   result registered in the cycle after it is accepted.
//   One item per cycle while out_stall is low; the whole decision runs in
//   the single back-end stage that updates the governor state on each pop.
// Reset and stall:
//   arst_n clears config to defaults, all governor state, the queue and the
//   result valid flag. While out_stall holds, the result stays put, the back
//   end pauses and the two-entry queue fills; in_stall rises once it is full.
module update_send_governor #(
	parameter int unsigned HEARTBEAT_MS = usg_pkg::HEARTBEAT_MS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  usg_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output usg_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [usg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [usg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import usg_pkg::*;

	cfg_t cfg_q;
	logic q_full, q_not_empty, push, pop;
	op_t  push_op, head_op;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled            <= 1'b0;
			cfg_q.target_id          <= 32'd0;
			cfg_q.segment            <= 8'd0;
			cfg_q.brightness         <= BRIGHTNESS_RST;
			cfg_q.send_brightness    <= 1'b0;
			cfg_q.keep_effect        <= 1'b0;
			cfg_q.update_interval_ms <= UPDATE_INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLED:         cfg_q.enabled            <= cfg_data[0];
				CFG_TARGET_ID:       cfg_q.target_id          <= cfg_data[31:0];
				CFG_SEGMENT:         cfg_q.segment            <= cfg_data[7:0];
				CFG_BRIGHTNESS:      cfg_q.brightness         <= cfg_data[7:0];
				CFG_SEND_BRIGHTNESS: cfg_q.send_brightness    <= cfg_data[0];
				CFG_KEEP_EFFECT:     cfg_q.keep_effect        <= cfg_data[0];
				CFG_UPDATE_INTERVAL: cfg_q.update_interval_ms <= cfg_data[15:0];
				default:             cfg_q                    <= cfg_q;
			endcase
		end
	end

	// intake and classification
	usg_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.op       (push_op)
	);

	// decoupling queue
	usg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	// governor engine
	usg_back #(
		.HEARTBEAT_MS (HEARTBEAT_MS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.op          (head_op),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

// File: sv/usg_front.sv
// front end: accepts items and classifies them into operations for the back end
module usg_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  usg_pkg::in_item_t  in_item,
	input  usg_pkg::cfg_t      cfg,
	input  logic               q_full,
	output logic               push,
	output usg_pkg::op_t       op
);
	import usg_pkg::*;

	logic ceil_caps;

	// take an item whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	// effective interval: the ceiling wins when nonzero and smaller
	assign ceil_caps = (in_item.interval_ceiling_ms != 16'd0) &&
		(in_item.interval_ceiling_ms < cfg.update_interval_ms);

	// operation record
	always_comb begin
		op.is_report   = (in_item.cmd == CMD_REPORT);
		op.now_ms      = in_item.now_ms;
		op.colour      = {in_item.red, in_item.green, in_item.blue};
		op.light_on    = in_item.light_on;
		op.force_req   = in_item.force_req;
		op.rel         = in_item.release_after_send;
		op.interval_ms = ceil_caps ? in_item.interval_ceiling_ms : cfg.update_interval_ms;
		op.send_ok     = in_item.send_ok;
	end

endmodule

// File: sv/usg_queue.sv
// two-entry queue of classified operations between front and back
module usg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  usg_pkg::op_t  push_op,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output usg_pkg::op_t  head_op
);
	import usg_pkg::*;

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_op   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/usg_back.sv
// back end: governor state, send decision and result register
module usg_back #(
	parameter int unsigned HEARTBEAT_MS = usg_pkg::HEARTBEAT_MS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  usg_pkg::cfg_t      cfg,
	input  logic               q_not_empty,
	input  usg_pkg::op_t       op,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output usg_pkg::out_item_t out_item
);
	import usg_pkg::*;

	localparam logic [31:0] HB_LIMIT = 32'(HEARTBEAT_MS);

	// governor state
	logic        rm_q, rc_q;
	logic [7:0]  fail_q;
	logic [14:0] backoff_q;
	logic [31:0] status_time_q, last_success_q, last_attempt_q;
	logic        have_attempt_q, have_last_q;
	logic [23:0] last_colour_q;
	logic        last_on_q;
	snap_t       snap_q;
	logic        pend_valid_q, pend_rel_q, pend_on_q;
	logic [23:0] pend_colour_q;

	// next-state values
	logic        rm_n, rc_n;
	logic [7:0]  fail_n;
	logic [14:0] backoff_n;
	logic        snap_en_clr, record_ok, record_report, take_send;
	logic        sent;

	logic        entering, leaving, send_now, retry_due, hb_due, dup_hit;
	logic        in_backoff, too_soon;
	logic [31:0] d_status, d_success, d_attempt;

	out_item_t   res;
	logic        out_valid_q;
	out_item_t   out_q;

	// fire when an operation waits and the result slot is free or being taken
	assign pop       = q_not_empty & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// elapsed times, modulo 2^32
	assign d_status  = op.now_ms - status_time_q;
	assign d_success = op.now_ms - last_success_q;
	assign d_attempt = op.now_ms - last_attempt_q;

	// duplicate check against the last successful state
	always_comb begin
		dup_hit = have_last_q && (snap_q.enabled == cfg.enabled) &&
			(snap_q.target_id == cfg.target_id) && (last_on_q == op.light_on);
		if (dup_hit && op.light_on) begin
			dup_hit = (snap_q.segment == cfg.segment) &&
				(snap_q.send_brightness == cfg.send_brightness) &&
				(snap_q.keep_effect == cfg.keep_effect) &&
				(!cfg.send_brightness || (snap_q.brightness == cfg.brightness)) &&
				(last_colour_q == op.colour);
		end
	end

	// send decision and state update
	always_comb begin
		rm_n          = rm_q;
		rc_n          = rc_q;
		fail_n        = fail_q;
		backoff_n     = backoff_q;
		snap_en_clr   = 1'b0;
		record_ok     = 1'b0;
		record_report = 1'b0;
		take_send     = 1'b0;
		sent          = 1'b0;
		entering      = op.rel & ~rm_q;
		leaving       = ~op.rel & rm_q;
		send_now      = op.force_req | entering | leaving;
		retry_due     = (fail_q != 8'd0);
		hb_due        = ~op.rel & have_last_q & (d_success >= HB_LIMIT);
		in_backoff    = ~send_now & retry_due & (d_status < {17'd0, backoff_q});
		too_soon      = ~send_now & ~retry_due & ~hb_due & have_attempt_q &
			(d_attempt < {16'd0, op.interval_ms});
		if (op.is_report) begin
			// outcome of the pending send
			if (pend_valid_q) begin
				record_report = 1'b1;
				if (op.send_ok) begin
					record_ok = 1'b1;
					fail_n    = 8'd0;
					backoff_n = 15'd0;
					if (pend_rel_q) begin
						rc_n = 1'b1;
					end
				end else begin
					fail_n    = (fail_q == FAIL_MAX) ? fail_q : fail_q + 8'd1;
					backoff_n = backoff_for(fail_n);
				end
			end
		end else if (!pend_valid_q) begin
			// release mode tracking
			if (!op.rel || entering || op.force_req) begin
				rc_n = 1'b0;
			end
			rm_n = op.rel;
			if (!cfg.enabled) begin
				snap_en_clr = 1'b1;
				fail_n      = 8'd0;
				backoff_n   = 15'd0;
				rm_n        = 1'b0;
				rc_n        = 1'b0;
			end else if (op.rel && rc_n && !op.force_req) begin
				sent = 1'b0;
			end else if (in_backoff) begin
				sent = 1'b0;
			end else if (!send_now && !retry_due && !hb_due && dup_hit) begin
				sent = 1'b0;
			end else if (too_soon) begin
				sent = 1'b0;
			end else begin
				take_send = 1'b1;
				sent      = 1'b1;
			end
		end
	end

	// result item
	always_comb begin
		res.send_request   = sent;
		res.send_red       = sent ? op.colour[23:16] : 8'd0;
		res.send_green     = sent ? op.colour[15:8] : 8'd0;
		res.send_blue      = sent ? op.colour[7:0] : 8'd0;
		res.send_on        = sent & op.light_on;
		res.failure_count  = fail_n;
		res.retry_delay_ms = backoff_n;
		res.release_done   = rc_n;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rm_q           <= 1'b0;
			rc_q           <= 1'b0;
			fail_q         <= 8'd0;
			backoff_q      <= 15'd0;
			status_time_q  <= 32'd0;
			last_success_q <= 32'd0;
			last_attempt_q <= 32'd0;
			have_attempt_q <= 1'b0;
			have_last_q    <= 1'b0;
			last_colour_q  <= 24'd0;
			last_on_q      <= 1'b0;
			snap_q         <= '0;
			pend_valid_q   <= 1'b0;
			pend_rel_q     <= 1'b0;
			pend_on_q      <= 1'b0;
			pend_colour_q  <= 24'd0;
		end else if (pop) begin
			rm_q      <= rm_n;
			rc_q      <= rc_n;
			fail_q    <= fail_n;
			backoff_q <= backoff_n;
			if (snap_en_clr) begin
				snap_q.enabled <= 1'b0;
			end
			if (record_report) begin
				status_time_q <= op.now_ms;
				pend_valid_q  <= 1'b0;
			end
			if (record_ok) begin
				last_success_q <= op.now_ms;
				last_colour_q  <= pend_colour_q;
				last_on_q      <= pend_on_q;
				have_last_q    <= 1'b1;
				snap_q         <= '{enabled: cfg.enabled, target_id: cfg.target_id,
					segment: cfg.segment, brightness: cfg.brightness,
					send_brightness: cfg.send_brightness, keep_effect: cfg.keep_effect};
			end
			if (take_send) begin
				last_attempt_q <= op.now_ms;
				have_attempt_q <= 1'b1;
				pend_valid_q   <= 1'b1;
				pend_rel_q     <= op.rel;
				pend_on_q      <= op.light_on;
				pend_colour_q  <= op.colour;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

endmodule

// File: verif/update_send_governor_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the update send governor with an in-bench decision model
module update_send_governor_tb;
	import usg_pkg::*;

	localparam int unsigned HOLD_CYCLES   = 64;
	localparam int unsigned PHASES        = 7;
	localparam int unsigned PHASE_ITEMS   = 11;
	localparam int unsigned SAT_PAIRS     = 256;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// decision model state
	cfg_t        cfg_m;
	snap_t       snap;
	bit          rel_mode, rel_done, attempted, have_sent, sent_on;
	bit          pend_valid, pend_rel, pend_on;
	bit [7:0]    fails;
	bit [14:0]   backoff;
	bit [31:0]   t_status, t_success, t_attempt;
	bit [23:0]   sent_colour, pend_colour;

	// expected decisions, oldest first
	out_item_t   decision_q[$];
	out_item_t   head;

	// stimulus bookkeeping
	bit [31:0]   wall;
	bit          rel_pref;
	bit          steady_tx;
	int          burst_left;
	int          hold_asks;
	int          hold_taken;
	int          n_items, n_reports, n_cfg_writes;
	int          bad_results, sends_seen, releases_seen;
	int          leftover;
	int          drain_wait;
	int          peak_fails;

	update_send_governor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL update_send_governor");
		$finish;
	end

	// backoff step for a failure count
	function automatic logic [14:0] delay_after(input logic [7:0] n);
		case (n)
			8'd0, 8'd1: return BACKOFF_1;
			8'd2: return BACKOFF_2;
			8'd3: return BACKOFF_3;
			8'd4: return BACKOFF_4;
			default: return BACKOFF_5;
		endcase
	endfunction

	// is the request the same as what last went out under the same config
	function automatic bit same_as_sent(input logic [23:0] colour, input logic on);
		if (!have_sent) return 1'b0;
		if (snap.enabled != cfg_m.enabled) return 1'b0;
		if (snap.target_id != cfg_m.target_id) return 1'b0;
		if (sent_on != on) return 1'b0;
		if (!on) return 1'b1;
		if (snap.segment != cfg_m.segment) return 1'b0;
		if (snap.send_brightness != cfg_m.send_brightness) return 1'b0;
		if (snap.keep_effect != cfg_m.keep_effect) return 1'b0;
		if (cfg_m.send_brightness && snap.brightness != cfg_m.brightness) return 1'b0;
		return sent_colour == colour;
	endfunction

	// update request: returns 1 when a send starts
	function automatic bit try_update(input in_item_t it);
		logic [23:0] colour;
		logic [15:0] interval;
		logic [31:0] gap_ms;
		bit          rel, entering, leaving, send_now, retry_due, beat_due, quiet;
		colour = {it.red, it.green, it.blue};
		rel = it.release_after_send;
		// a send in flight swallows the request whole
		if (pend_valid) return 1'b0;
		entering = rel && !rel_mode;
		leaving = !rel && rel_mode;
		if (!rel || entering || it.force_req) rel_done = 1'b0;
		rel_mode = rel;
		if (!cfg_m.enabled) begin
			snap.enabled = 1'b0;
			fails = '0;
			backoff = '0;
			rel_mode = 1'b0;
			rel_done = 1'b0;
			return 1'b0;
		end
		if (rel && rel_done && !it.force_req) return 1'b0;
		send_now = it.force_req || entering || leaving;
		gap_ms = it.now_ms - t_status;
		if (!send_now && fails != 0 && gap_ms < {17'd0, backoff}) return 1'b0;
		retry_due = fails != 0;
		gap_ms = it.now_ms - t_success;
		beat_due = !rel && have_sent && gap_ms >= HEARTBEAT_MS_DEF;
		quiet = !send_now && !retry_due && !beat_due;
		if (quiet && same_as_sent(colour, it.light_on)) return 1'b0;
		// throttle, with the item's ceiling when it is tighter
		interval = cfg_m.update_interval_ms;
		if (it.interval_ceiling_ms != 0 && it.interval_ceiling_ms < interval)
			interval = it.interval_ceiling_ms;
		gap_ms = it.now_ms - t_attempt;
		if (quiet && attempted && gap_ms < {16'd0, interval}) return 1'b0;
		t_attempt = it.now_ms;
		attempted = 1'b1;
		pend_valid = 1'b1;
		pend_rel = rel;
		pend_on = it.light_on;
		pend_colour = colour;
		return 1'b1;
	endfunction

	// send outcome report
	function automatic void take_report(input in_item_t it);
		if (!pend_valid) return;
		t_status = it.now_ms;
		if (it.send_ok) begin
			fails = '0;
			backoff = '0;
			t_success = it.now_ms;
			sent_colour = pend_colour;
			sent_on = pend_on;
			snap.enabled = cfg_m.enabled;
			snap.target_id = cfg_m.target_id;
			snap.segment = cfg_m.segment;
			snap.brightness = cfg_m.brightness;
			snap.send_brightness = cfg_m.send_brightness;
			snap.keep_effect = cfg_m.keep_effect;
			have_sent = 1'b1;
			if (pend_rel) rel_done = 1'b1;
		end else begin
			if (fails != FAIL_MAX) fails = fails + 8'd1;
			backoff = delay_after(fails);
		end
		pend_valid = 1'b0;
	endfunction

	// decision for one accepted item
	function automatic out_item_t expected_decision(input in_item_t it);
		out_item_t r;
		bit        sent;
		sent = 1'b0;
		if (it.cmd == CMD_UPDATE) sent = try_update(it);
		else take_report(it);
		r = '0;
		r.send_request = sent;
		if (sent) begin
			r.send_red = it.red;
			r.send_green = it.green;
			r.send_blue = it.blue;
			r.send_on = it.light_on;
		end
		r.failure_count = fails;
		r.retry_delay_ms = backoff;
		r.release_done = rel_done;
		return r;
	endfunction

	function automatic in_item_t update_item(input logic [31:0] t, input logic [23:0] c,
		input logic on, input logic frc, input logic rel, input logic [15:0] ceil_ms);
		in_item_t it;
		it = '0;
		it.cmd = CMD_UPDATE;
		it.now_ms = t;
		{it.red, it.green, it.blue} = c;
		it.light_on = on;
		it.force_req = frc;
		it.release_after_send = rel;
		it.interval_ceiling_ms = ceil_ms;
		return it;
	endfunction

	function automatic in_item_t report_item(input logic [31:0] t, input logic ok);
		in_item_t it;
		it = '0;
		it.cmd = CMD_REPORT;
		it.now_ms = t;
		it.send_ok = ok;
		return it;
	endfunction

	// mostly update/report pairs with moving time, a little noise
	function automatic in_item_t random_item();
		in_item_t    it;
		int          pick, sel;
		int unsigned step;
		it.cmd = 1'($urandom_range(0, 1));
		it.now_ms = $urandom;
		it.red = 8'($urandom_range(0, 255));
		it.green = 8'($urandom_range(0, 255));
		it.blue = 8'($urandom_range(0, 255));
		it.light_on = 1'($urandom_range(0, 1));
		it.force_req = 1'($urandom_range(0, 1));
		it.release_after_send = 1'($urandom_range(0, 1));
		it.interval_ceiling_ms = 16'($urandom_range(0, 65535));
		it.send_ok = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 8) return it;
		sel = $urandom_range(0, 99);
		if (sel < 60) step = $urandom_range(0, 150);
		else if (sel < 85) step = $urandom_range(150, 3000);
		else if (sel < 95) step = $urandom_range(3000, 40000);
		else step = $urandom_range(40000, 70000);
		wall = wall + step;
		it.now_ms = wall;
		// a pending send is usually answered, an idle one rarely
		if (pend_valid ? (pick < 85) : (pick < 13)) begin
			it.cmd = CMD_REPORT;
			it.send_ok = ($urandom_range(0, 9) < 7);
			return it;
		end
		it.cmd = CMD_UPDATE;
		if ($urandom_range(0, 99) < 65) begin
			case ($urandom_range(0, 3))
				0: {it.red, it.green, it.blue} = 24'h000000;
				1: {it.red, it.green, it.blue} = 24'hFFFFFF;
				2: {it.red, it.green, it.blue} = 24'h123456;
				default: {it.red, it.green, it.blue} = 24'hFF8000;
			endcase
		end
		if ($urandom_range(0, 9) == 0) rel_pref = !rel_pref;
		it.release_after_send = rel_pref;
		it.force_req = ($urandom_range(0, 9) == 0);
		it.light_on = ($urandom_range(0, 4) != 0);
		sel = $urandom_range(0, 99);
		if (sel < 70) it.interval_ceiling_ms = '0;
		else if (sel < 90) it.interval_ceiling_ms = 16'($urandom_range(1, 200));
		return it;
	endfunction

	// offer one item in bursts, record its decision once taken
	task automatic push_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = steady_tx ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_item = it;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decision_q.push_back(expected_decision(it));
		burst_left--;
		n_items++;
		if (it.cmd == CMD_REPORT) n_reports++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (decision_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ENABLED: cfg_m.enabled = val[0];
			CFG_TARGET_ID: cfg_m.target_id = val;
			CFG_SEGMENT: cfg_m.segment = val[7:0];
			CFG_BRIGHTNESS: cfg_m.brightness = val[7:0];
			CFG_SEND_BRIGHTNESS: cfg_m.send_brightness = val[0];
			CFG_KEEP_EFFECT: cfg_m.keep_effect = val[0];
			CFG_UPDATE_INTERVAL: cfg_m.update_interval_ms = val[15:0];
			default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(input logic en, input logic [31:0] tgt, input logic [7:0] seg,
		input logic [7:0] bri, input logic sb, input logic ke, input logic [15:0] ivl);
		write_reg(CFG_ENABLED, {31'd0, en});
		write_reg(CFG_TARGET_ID, tgt);
		write_reg(CFG_SEGMENT, {24'd0, seg});
		write_reg(CFG_BRIGHTNESS, {24'd0, bri});
		write_reg(CFG_SEND_BRIGHTNESS, {31'd0, sb});
		write_reg(CFG_KEEP_EFFECT, {31'd0, ke});
		write_reg(CFG_UPDATE_INTERVAL, {16'd0, ivl});
	endtask

	// zero, top or anything in between; first phases pin the extremes
	function automatic logic [31:0] span_pick(input int phase, input logic [31:0] top);
		if (phase == 0) return '0;
		if (phase == 1) return top;
		case ($urandom_range(0, 2))
			0: return '0;
			1: return top;
			default: return (top == 32'hFFFF_FFFF) ? $urandom : 32'($urandom_range(0, top));
		endcase
	endfunction

	// disabled at reset: update clears status, lone report ignored
	task automatic test_after_reset();
		push_item(update_item(32'd10, 24'h123456, 1'b1, 1'b1, 1'b1, 16'd0));
		push_item(report_item(32'd20, 1'b1));
		drain_results();
	endtask

	// extremes and each rule in turn
	task automatic test_directed_cases();
		write_all(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1'b1, 1'b1, 16'hFFFF);
		wall = 32'd1000;
		// first attempt, then a request swallowed while it is pending
		push_item(update_item(wall, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 16'hFFFF));
		push_item(update_item(wall + 1, 24'h000000, 1'b0, 1'b1, 1'b1, 16'd0));
		push_item(report_item(wall + 2, 1'b0));
		// inside the backoff window, then once it has run out
		push_item(update_item(wall + 500, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(update_item(wall + 1002, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(report_item(wall + 1003, 1'b0));
		wall = wall + 1004;
		// forced success, then a duplicate and a heartbeat
		push_item(update_item(wall, 24'h00FF00, 1'b1, 1'b1, 1'b0, 16'd0));
		push_item(report_item(wall + 1, 1'b1));
		push_item(update_item(wall + 200, 24'h00FF00, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(update_item(wall + 31000, 24'h00FF00, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(report_item(wall + 31001, 1'b1));
		wall = wall + 31002;
		// release mode: enter, held once done, forced, left
		push_item(update_item(wall, 24'h0000FF, 1'b1, 1'b0, 1'b1, 16'd0));
		push_item(report_item(wall + 1, 1'b1));
		push_item(update_item(wall + 2, 24'h0000FF, 1'b1, 1'b0, 1'b1, 16'd0));
		push_item(update_item(wall + 3, 24'h0000FF, 1'b1, 1'b1, 1'b1, 16'd0));
		push_item(report_item(wall + 4, 1'b1));
		push_item(update_item(wall + 5, 24'h0000FF, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(report_item(wall + 6, 1'b1));
		// ceiling tighter than the interval: too soon, then just in time
		push_item(update_item(wall + 9, 24'h808080, 1'b1, 1'b0, 1'b0, 16'd5));
		push_item(update_item(wall + 10, 24'h808080, 1'b0, 1'b0, 1'b0, 16'd5));
		push_item(report_item(wall + 11, 1'b1));
		wall = wall + 12;
		drain_results();
	endtask

	// backoff measured across the 32-bit wrap of the clock
	task automatic test_time_wrap();
		push_item(update_item(32'hFFFF_FF00, 24'hA5A5A5, 1'b1, 1'b1, 1'b0, 16'd0));
		push_item(report_item(32'hFFFF_FF01, 1'b0));
		push_item(update_item(32'h0000_0100, 24'hA5A5A5, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(update_item(32'h0000_0400, 24'hA5A5A5, 1'b1, 1'b0, 1'b0, 16'd0));
		push_item(report_item(32'hFFFF_FFFF, 1'b1));
		wall = 32'h0000_0500;
		drain_results();
	endtask

	// failures up past the ceiling of the counter, then one success
	task automatic test_fail_saturation();
		for (int i = 0; i < SAT_PAIRS; i++) begin
			push_item(update_item(wall, 24'h3C3C3C, 1'b1, 1'b1, 1'b0, 16'd0));
			push_item(report_item(wall + 1, 1'b0));
			wall = wall + 2;
		end
		push_item(update_item(wall, 24'h3C3C3C, 1'b1, 1'b1, 1'b0, 16'd0));
		push_item(report_item(wall + 1, 1'b1));
		wall = wall + 2;
		drain_results();
	endtask

	// receiver holds off while items keep coming, so the queue fills
	task automatic test_backpressure();
		steady_tx = 1'b1;
		hold_asks++;
		for (int i = 0; i < 30; i++) push_item(random_item());
		drain_results();
		steady_tx = 1'b0;
	endtask

	// random traffic in phases, fresh config between phases
	task automatic test_random_phases();
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_reg(CFG_ENABLED, (p == 2) ? 32'd0 : 32'd1);
			write_reg(CFG_TARGET_ID, span_pick(p, 32'hFFFF_FFFF));
			write_reg(CFG_SEGMENT, span_pick(p, 32'd255));
			write_reg(CFG_BRIGHTNESS, span_pick(p, 32'd255));
			write_reg(CFG_SEND_BRIGHTNESS, span_pick(p, 32'd1));
			write_reg(CFG_KEEP_EFFECT, span_pick(p, 32'd1));
			if (p < 2 || $urandom_range(0, 3) == 0)
				write_reg(CFG_UPDATE_INTERVAL, span_pick(p, 32'd65535));
			else
				write_reg(CFG_UPDATE_INTERVAL, 32'($urandom_range(0, 400)));
			steady_tx = (p % 3 == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) push_item(random_item());
		end
		steady_tx = 1'b0;
		drain_results();
	endtask

	// receiver stall: long holds on request, otherwise a mode that changes now and then
	initial begin
		int       hold_left, mode_left;
		rx_mode_e rx_mode;
		bit [7:0] pat;
		out_stall = 1'b0;
		hold_left = 0;
		mode_left = 100;
		rx_mode = RX_FREE;
		pat = 8'b1001_0110;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_taken) begin
				hold_taken = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 2));
				mode_left = $urandom_range(40, 300);
			end
			mode_left--;
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_FREE: out_stall = 1'b0;
					RX_RANDOM: out_stall = ($urandom_range(0, 3) == 0);
					default: begin
						out_stall = pat[0];
						pat = {pat[0], pat[7:1]};
					end
				endcase
			end
		end
	end

	// compare each taken result with the oldest expected decision
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (decision_q.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("%0t: result with nothing outstanding: %h", $time, out_item);
			end else begin
				head = decision_q.pop_front();
				if (out_item.send_request !== head.send_request
					|| out_item.send_red !== head.send_red
					|| out_item.send_green !== head.send_green
					|| out_item.send_blue !== head.send_blue
					|| out_item.send_on !== head.send_on
					|| out_item.failure_count !== head.failure_count
					|| out_item.retry_delay_ms !== head.retry_delay_ms
					|| out_item.release_done !== head.release_done) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("%0t: result mismatch", $time);
						$display("  expected req %0d rgb %h %h %h on %0d fails %0d delay %0d done %0d",
							head.send_request, head.send_red, head.send_green, head.send_blue,
							head.send_on, head.failure_count, head.retry_delay_ms, head.release_done);
						$display("  actual   req %0d rgb %h %h %h on %0d fails %0d delay %0d done %0d",
							out_item.send_request, out_item.send_red, out_item.send_green,
							out_item.send_blue, out_item.send_on, out_item.failure_count,
							out_item.retry_delay_ms, out_item.release_done);
					end
				end
			end
			if (out_item.send_request === 1'b1) sends_seen++;
			if (out_item.release_done === 1'b1) releases_seen++;
			if (out_item.failure_count > peak_fails) peak_fails = out_item.failure_count;
		end
	end

	// reset, tests in turn, final verdict
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_m = '0;
		cfg_m.brightness = BRIGHTNESS_RST;
		cfg_m.update_interval_ms = UPDATE_INTERVAL_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_directed_cases();
		test_time_wrap();
		test_fail_saturation();
		test_backpressure();
		test_random_phases();

		// bounded wait for stragglers
		@(negedge clk);
		in_valid = 1'b0;
		drain_wait = 0;
		while (decision_q.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (10) @(posedge clk);
		leftover = decision_q.size();
		if (leftover != 0)
			$display("%0d expected results never arrived", leftover);

		$display("run covered %0d items (%0d reports) and %0d register writes",
			n_items, n_reports, n_cfg_writes);
		$display("%0d sends started, failure count peaked at %0d, %0d results with release done",
			sends_seen, peak_fails, releases_seen);
		if (bad_results == 0 && leftover == 0) begin
			$display("PASS update_send_governor");
		end else begin
			$display("FAIL update_send_governor");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/usg_pkg.sv
sv/usg_front.sv
sv/usg_queue.sv
sv/usg_back.sv
sv/update_send_governor.sv
verif/update_send_governor_tb.sv
